>>> rtl/core/serial_tuning_command_parser_defines.svh
// Assertion macros shared by the serial tuning command parser RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SERIAL_TUNING_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_TUNING_COMMAND_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define STCP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define STCP_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define STCP_ASSERT(label, clk, rstn, prop, msg)
`define STCP_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/core/stcp_pkg.sv
// Types, command codes and helper functions of the serial tuning command parser.
// Depends on nothing; used by the decoder and the top level.
package stcp_pkg;

    localparam logic [3:0]  PEND_NONE = 4'd15;
    localparam logic [14:0] VALUE_MAX = 15'd32767;

    localparam logic [3:0] NUM_SPEED_KP  = 4'd0;
    localparam logic [3:0] NUM_SPEED_KI  = 4'd1;
    localparam logic [3:0] NUM_TORQUE_KP = 4'd2;
    localparam logic [3:0] NUM_TORQUE_KI = 4'd3;
    localparam logic [3:0] NUM_DEADTIME  = 4'd4;
    localparam logic [3:0] NUM_CUR_LPF   = 4'd5;
    localparam logic [3:0] NUM_VEL_LPF   = 4'd6;
    localparam logic [3:0] NUM_TORQUE_SP = 4'd7;
    localparam logic [3:0] NUM_SPEED_SP  = 4'd8;
    localparam logic [3:0] NUM_COG_CLAMP = 4'd9;

    localparam logic [4:0] CMD_INL_ENABLE = 5'd10;
    localparam logic [4:0] CMD_INL_SIGN   = 5'd11;
    localparam logic [4:0] CMD_INL_REARM  = 5'd12;
    localparam logic [4:0] CMD_FB_SELECT  = 5'd13;
    localparam logic [4:0] CMD_STEP_CAP   = 5'd14;
    localparam logic [4:0] CMD_MONITOR    = 5'd15;
    localparam logic [4:0] CMD_AGC_SWEEP  = 5'd16;
    localparam logic [4:0] CMD_CAL_ARM    = 5'd17;
    localparam logic [4:0] CMD_CAL_STOP   = 5'd18;
    localparam logic [4:0] CMD_COG_FF     = 5'd19;

    typedef struct packed {
        logic [3:0]  pend;
        logic [14:0] acc;
        logic        have;
        logic        mon;
    } parse_state_t;

    typedef struct packed {
        logic [4:0]        command;
        logic signed [15:0] value;
        logic              last;
    } result_t;

    typedef struct packed {
        parse_state_t next;
        logic [1:0]   count;
        result_t      r0;
        result_t      r1;
    } decode_out_t;

    function automatic logic [3:0] numeric_code(input logic [7:0] ch);
        logic [3:0] code;
        unique case (ch)
            "p":     code = NUM_SPEED_KP;
            "i":     code = NUM_SPEED_KI;
            "P":     code = NUM_TORQUE_KP;
            "I":     code = NUM_TORQUE_KI;
            "D":     code = NUM_DEADTIME;
            "f":     code = NUM_CUR_LPF;
            "F":     code = NUM_VEL_LPF;
            "t":     code = NUM_TORQUE_SP;
            "s":     code = NUM_SPEED_SP;
            "C":     code = NUM_COG_CLAMP;
            default: code = PEND_NONE;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/core/stcp_decode.sv
// Combinational byte decoder of the serial tuning command parser.
// Depends on stcp_pkg; computes the next parse state and up to two results.
module stcp_decode (
    input  logic [7:0]                 byte_req,
    input  logic                       cal_running,
    input  stcp_pkg::parse_state_t     state,
    output stcp_pkg::decode_out_t      dec
);
    import stcp_pkg::*;

    logic        is_digit;
    logic [18:0] wide_acc;
    logic        emit_num;
    logic        act_valid;
    logic [4:0]  act_cmd;
    logic signed [15:0] act_val;
    result_t     num_res;
    result_t     act_res;

    assign is_digit = (byte_req >= "0") && (byte_req <= "9");
    assign wide_acc = ({4'b0, state.acc} << 3) + ({4'b0, state.acc} << 1)
                    + {15'b0, byte_req[3:0]};

    always_comb begin
        dec       = '0;
        dec.next  = state;
        emit_num  = 1'b0;
        act_valid = 1'b0;
        act_cmd   = CMD_INL_ENABLE;
        act_val   = 16'sd0;
        if (is_digit) begin
            if (state.pend != PEND_NONE) begin
                dec.next.acc  = (wide_acc > {4'b0, VALUE_MAX}) ? VALUE_MAX : wide_acc[14:0];
                dec.next.have = 1'b1;
            end
        end else begin
            emit_num      = (state.pend != PEND_NONE) && state.have;
            dec.next.pend = PEND_NONE;
            dec.next.acc  = '0;
            dec.next.have = 1'b0;
            unique case (byte_req)
                "e": begin act_valid = 1'b1; act_cmd = CMD_INL_ENABLE; act_val = 16'sd1; end
                "d": begin act_valid = 1'b1; act_cmd = CMD_INL_ENABLE; end
                "+": begin act_valid = 1'b1; act_cmd = CMD_INL_SIGN; act_val = 16'sd1; end
                "-": begin act_valid = 1'b1; act_cmd = CMD_INL_SIGN; act_val = -16'sd1; end
                "c": begin act_valid = 1'b1; act_cmd = CMD_INL_REARM; end
                "v": begin act_valid = 1'b1; act_cmd = CMD_FB_SELECT; act_val = 16'sd1; end
                "b": begin act_valid = 1'b1; act_cmd = CMD_FB_SELECT; end
                "g": begin act_valid = 1'b1; act_cmd = CMD_STEP_CAP; end
                "r": begin
                    act_valid    = 1'b1;
                    act_cmd      = CMD_MONITOR;
                    dec.next.mon = !state.mon;
                    act_val      = {15'b0, !state.mon};
                end
                "a": begin act_valid = 1'b1; act_cmd = CMD_AGC_SWEEP; end
                "y": begin act_valid = 1'b1; act_cmd = CMD_CAL_ARM; end
                "Y": begin act_valid = cal_running; act_cmd = CMD_CAL_STOP; end
                "K": begin act_valid = 1'b1; act_cmd = CMD_COG_FF; act_val = 16'sd1; end
                "k": begin act_valid = 1'b1; act_cmd = CMD_COG_FF; end
                default: dec.next.pend = numeric_code(byte_req);
            endcase
        end

        num_res.command = {1'b0, state.pend};
        num_res.value   = {1'b0, state.acc};
        num_res.last    = !act_valid;
        act_res.command = act_cmd;
        act_res.value   = act_val;
        act_res.last    = 1'b1;

        dec.count = {1'b0, emit_num} + {1'b0, act_valid};
        dec.r0    = emit_num ? num_res : act_res;
        dec.r1    = act_res;
    end

endmodule

>>> rtl/core/serial_tuning_command_parser.sv
// Top level of the serial tuning command parser: parse state and result queue.
// Depends on stcp_pkg, stcp_decode and serial_tuning_command_parser_defines.svh.
//
// The parser takes one received character per transaction and returns the commands it
// completes, one per transaction, with tlast set on the final one caused by that character.
// Each character is decoded in the cycle it is accepted and its results land in a two-entry
// output queue, so the block takes one character per clock cycle while results drain at the
// same pace. s_tready is high when the queue is empty or its single entry is being taken in
// that cycle; a character that both completes a number and triggers an action yields two
// transactions and holds s_tready low while the first drains.
`include "serial_tuning_command_parser_defines.svh"

module serial_tuning_command_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_req
    input  logic        s_tuser,   // [0] cal_running
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] command, [20:5] value, [23:21] zero
    output logic        m_tlast    // last
);
    import stcp_pkg::*;

    parse_state_t state_reg, state_next;
    decode_out_t  dec;
    result_t      q0_reg, q0_next;
    result_t      q1_reg, q1_next;
    logic [1:0]   count_reg, count_next;
    logic         push;
    logic         pop;

    stcp_decode u_decode (
        .byte_req    (s_tdata),
        .cal_running (s_tuser),
        .state       (state_reg),
        .dec         (dec)
    );

    assign m_tvalid = (count_reg != 2'd0);
    assign s_tready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);
    assign pop      = m_tvalid && m_tready;
    assign push     = s_tvalid && s_tready;
    assign m_tdata  = {3'b000, q0_reg.value, q0_reg.command};
    assign m_tlast  = q0_reg.last;

    always_comb begin
        state_next = state_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        count_next = count_reg;
        if (push) begin
            state_next = dec.next;
            q0_next    = dec.r0;
            q1_next    = dec.r1;
            count_next = dec.count;
        end else if (pop) begin
            q0_next    = q1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pend <= PEND_NONE;
            state_reg.acc  <= '0;
            state_reg.have <= 1'b0;
            state_reg.mon  <= 1'b0;
            count_reg      <= 2'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    `STCP_NEVER(a_count_range, aclk, aresetn, count_reg == 2'd3, "result queue overfilled")
    `STCP_ASSERT(a_first_not_last, aclk, aresetn, (count_reg == 2'd2) |-> !q0_reg.last, "first of two results marked last")
    `STCP_ASSERT(a_idle_clear, aclk, aresetn, (state_reg.pend == PEND_NONE) |-> ((state_reg.acc == 15'd0) && !state_reg.have), "value held with no pending command")
    `STCP_ASSERT(a_nodigit_zero, aclk, aresetn, !state_reg.have |-> (state_reg.acc == 15'd0), "value nonzero before any digit")
    `STCP_ASSERT(a_monitor_on_accept, aclk, aresetn, !$stable(state_reg.mon) |-> $past(push), "monitor bit changed without a transaction")

endmodule

>>> sim/tb_serial_tuning_command_parser.sv
// Self-checking testbench for the serial tuning command parser.
// Depends on stcp_pkg and the serial_tuning_command_parser RTL. A directed table and a random
// character stream are checked against table results or a local model of the parser, with random stalls.
`timescale 1ns / 100ps

module tb_serial_tuning_command_parser;
    import stcp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 16;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [7:0] ch;
        logic       cal;
        logic       typed;
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] byte_req
    logic        s_tuser;   // [0] cal_running
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [4:0] command, [20:5] value, [23:21] zero
    logic        m_tlast;

    logic [3:0]  pend_cmd;
    logic [14:0] acc_value;
    logic        seen_digit;
    logic        monitor_bit;

    result_t     awaited_cmds[$];
    stim_row_t   directed_rows[$];
    int          errors = 0;
    int          results_seen = 0;
    int          useful_items;
    int          no_gap_left;
    int          cycle_count = 0;
    logic        long_hold_done = 1'b0;
    string       num_letters = "piPIDfFtsC";
    string       act_letters = "ed+-cvbgrayYKk";

    serial_tuning_command_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic result_t mk_result(input logic [4:0] cmd, input logic signed [15:0] val,
                                          input logic fin);
        result_t r;
        r.command = cmd;
        r.value   = val;
        r.last    = fin;
        return r;
    endfunction

    function automatic int predict_commands(input logic [7:0] ch, input logic cal,
                                            output result_t first, output result_t second);
        int                 n;
        int                 grown;
        logic               has_act;
        logic [4:0]         act_cmd;
        logic signed [15:0] act_val;
        first   = '0;
        second  = '0;
        n       = 0;
        has_act = 1'b1;
        act_cmd = '0;
        act_val = 16'sd0;
        if (ch >= "0" && ch <= "9") begin
            if (pend_cmd != PEND_NONE) begin
                grown      = acc_value * 10 + (ch - "0");
                acc_value  = (grown > VALUE_MAX) ? VALUE_MAX : grown[14:0];
                seen_digit = 1'b1;
            end
            return 0;
        end
        if (pend_cmd != PEND_NONE && seen_digit) begin
            first = mk_result({1'b0, pend_cmd}, {1'b0, acc_value}, 1'b0);
            n     = 1;
        end
        pend_cmd   = PEND_NONE;
        acc_value  = '0;
        seen_digit = 1'b0;
        case (ch)
            "e": begin
                act_cmd = CMD_INL_ENABLE;
                act_val = 16'sd1;
            end
            "d": act_cmd = CMD_INL_ENABLE;
            "+": begin
                act_cmd = CMD_INL_SIGN;
                act_val = 16'sd1;
            end
            "-": begin
                act_cmd = CMD_INL_SIGN;
                act_val = -16'sd1;
            end
            "c": act_cmd = CMD_INL_REARM;
            "v": begin
                act_cmd = CMD_FB_SELECT;
                act_val = 16'sd1;
            end
            "b": act_cmd = CMD_FB_SELECT;
            "g": act_cmd = CMD_STEP_CAP;
            "r": begin
                monitor_bit = !monitor_bit;
                act_cmd     = CMD_MONITOR;
                act_val     = {15'd0, monitor_bit};
            end
            "a": act_cmd = CMD_AGC_SWEEP;
            "y": act_cmd = CMD_CAL_ARM;
            "Y": begin
                act_cmd = CMD_CAL_STOP;
                has_act = cal;
            end
            "K": begin
                act_cmd = CMD_COG_FF;
                act_val = 16'sd1;
            end
            "k": act_cmd = CMD_COG_FF;
            "p": begin
                pend_cmd = NUM_SPEED_KP;
                has_act  = 1'b0;
            end
            "i": begin
                pend_cmd = NUM_SPEED_KI;
                has_act  = 1'b0;
            end
            "P": begin
                pend_cmd = NUM_TORQUE_KP;
                has_act  = 1'b0;
            end
            "I": begin
                pend_cmd = NUM_TORQUE_KI;
                has_act  = 1'b0;
            end
            "D": begin
                pend_cmd = NUM_DEADTIME;
                has_act  = 1'b0;
            end
            "f": begin
                pend_cmd = NUM_CUR_LPF;
                has_act  = 1'b0;
            end
            "F": begin
                pend_cmd = NUM_VEL_LPF;
                has_act  = 1'b0;
            end
            "t": begin
                pend_cmd = NUM_TORQUE_SP;
                has_act  = 1'b0;
            end
            "s": begin
                pend_cmd = NUM_SPEED_SP;
                has_act  = 1'b0;
            end
            "C": begin
                pend_cmd = NUM_COG_CLAMP;
                has_act  = 1'b0;
            end
            default: has_act = 1'b0;
        endcase
        if (has_act) begin
            if (n == 0) begin
                first = mk_result(act_cmd, act_val, 1'b1);
            end else begin
                second = mk_result(act_cmd, act_val, 1'b1);
            end
            n++;
        end else if (n > 0) begin
            first.last = 1'b1;
        end
        return n;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(input logic [7:0] ch, input logic cal, input logic typed,
                           input logic [1:0] count, input result_t r0, input result_t r1);
        stim_row_t row;
        row.ch    = ch;
        row.cal   = cal;
        row.typed = typed;
        row.count = count;
        row.r0    = r0;
        row.r1    = r1;
        directed_rows.push_back(row);
    endtask

    task automatic send_byte(input stim_row_t row);
        int         gap;
        int         n;
        result_t    a;
        result_t    b;
        logic [20:0] snap;
        if (no_gap_left > 0) begin
            no_gap_left--;
            gap = 0;
        end else if ($urandom_range(0, 149) == 0) begin
            no_gap_left = 40;
            gap = 0;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.ch;
        s_tuser  <= row.cal;
        do @(posedge aclk); while (!s_tready);
        snap = {pend_cmd, acc_value, seen_digit, monitor_bit};
        n = predict_commands(row.ch, row.cal, a, b);
        if (row.typed) begin
            n = row.count;
            a = row.r0;
            b = row.r1;
        end
        if (n > 0) awaited_cmds.push_back(a);
        if (n > 1) awaited_cmds.push_back(b);
        if (n > 0 || snap != {pend_cmd, acc_value, seen_digit, monitor_bit}) useful_items++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        stim_row_t row;
        row       = '0;
        row.ch    = ch;
        row.cal   = 1'($urandom_range(0, 1));
        send_byte(row);
    endtask

    task automatic send_random_run();
        int roll;
        int ndig;
        int k;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            send_char(num_letters[$urandom_range(0, 9)]);
            ndig = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 7);
            repeat (ndig) send_char(8'("0" + $urandom_range(0, 9)));
            k = $urandom_range(0, 3);
            if (k < 2) begin
                send_char(act_letters[$urandom_range(0, 13)]);
            end else if (k == 2) begin
                case ($urandom_range(0, 3))
                    0: send_char(8'h0D);
                    1: send_char(8'h0A);
                    2: send_char(" ");
                    default: send_char(8'($urandom_range(0, 255)));
                endcase
            end
        end else if (roll < 85) begin
            send_char(num_letters[$urandom_range(0, 9)]);
            case ($urandom_range(0, 2))
                0: send_char(num_letters[$urandom_range(0, 9)]);
                1: send_char(act_letters[$urandom_range(0, 13)]);
                default: begin
                    send_char(" ");
                    send_char(8'("0" + $urandom_range(0, 9)));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.command = m_tdata[4:0];
            got.value   = m_tdata[20:5];
            got.last    = m_tlast;
            results_seen++;
            if (awaited_cmds.size() == 0) begin
                errors++;
                $display("%0t: expected no transaction, got command %0d value %0d last %0d",
                         $time, got.command, got.value, got.last);
            end else begin
                want = awaited_cmds.pop_front();
                if (got.command !== want.command || got.value !== want.value ||
                    got.last !== want.last) begin
                    errors++;
                    $display("%0t: expected command %0d value %0d last %0d,",
                             $time, want.command, want.value, want.last);
                    $display("%0t: got command %0d value %0d last %0d",
                             $time, got.command, got.value, got.last);
                end
            end
        end
    end

    initial begin : drive_result_ready
        int on_len;
        int off_len;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!long_hold_done && results_seen >= 100) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
            end
            on_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (on_len) @(posedge aclk);
            off_len = pick_gap();
            if (off_len > 0) begin
                m_tready <= 1'b0;
                repeat (off_len) @(posedge aclk);
            end
        end
    end

    initial begin : drive_characters
        int   idx;
        int   drain;
        logic pause_done;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        useful_items   = 0;
        no_gap_left    = 0;
        pause_done     = 1'b0;
        pend_cmd       = PEND_NONE;
        acc_value      = '0;
        seen_digit     = 1'b0;
        monitor_bit    = 1'b0;

        add_row("5", 1'b0, 1'b1, 2'd0, '0, '0);
        add_row("r", 1'b0, 1'b1, 2'd1, mk_result(CMD_MONITOR, 16'sd1, 1'b1), '0);
        add_row("p", 1'b0, 1'b1, 2'd0, '0, '0);
        repeat (5) add_row("3", 1'b1, 1'b1, 2'd0, '0, '0);
        add_row("e", 1'b0, 1'b1, 2'd2, mk_result({1'b0, NUM_SPEED_KP}, 16'sd32767, 1'b0),
                mk_result(CMD_INL_ENABLE, 16'sd1, 1'b1));
        add_row("i", 1'b0, 1'b1, 2'd0, '0, '0);
        add_row("D", 1'b0, 1'b1, 2'd0, '0, '0);
        add_row("0", 1'b0, 1'b1, 2'd0, '0, '0);
        add_row("Y", 1'b0, 1'b1, 2'd1, mk_result({1'b0, NUM_DEADTIME}, 16'sd0, 1'b1), '0);
        add_row("Y", 1'b1, 1'b1, 2'd1, mk_result(CMD_CAL_STOP, 16'sd0, 1'b1), '0);
        add_row("-", 1'b0, 1'b1, 2'd1, mk_result(CMD_INL_SIGN, -16'sd1, 1'b1), '0);
        add_row("+", 1'b1, 1'b1, 2'd1, mk_result(CMD_INL_SIGN, 16'sd1, 1'b1), '0);
        add_row("C", 1'b0, 1'b1, 2'd0, '0, '0);
        add_row("1", 1'b0, 1'b1, 2'd0, '0, '0);
        add_row("2", 1'b0, 1'b1, 2'd0, '0, '0);
        add_row("k", 1'b0, 1'b0, 2'd0, '0, '0);
        add_row("d", 1'b1, 1'b0, 2'd0, '0, '0);
        add_row("c", 1'b0, 1'b0, 2'd0, '0, '0);
        add_row("v", 1'b1, 1'b0, 2'd0, '0, '0);
        add_row("b", 1'b0, 1'b0, 2'd0, '0, '0);
        add_row("g", 1'b1, 1'b0, 2'd0, '0, '0);
        add_row("a", 1'b0, 1'b0, 2'd0, '0, '0);
        add_row("y", 1'b1, 1'b0, 2'd0, '0, '0);
        add_row("K", 1'b0, 1'b0, 2'd0, '0, '0);
        add_row("r", 1'b1, 1'b0, 2'd0, '0, '0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (idx = 0; idx < directed_rows.size(); idx++) begin
            send_byte(directed_rows[idx]);
        end

        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            if (!pause_done && useful_items >= RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (awaited_cmds.size() != 0) @(posedge aclk);
                pause_done = 1'b1;
            end
            send_random_run();
        end

        s_tvalid <= 1'b0;
        drain = 0;
        while (awaited_cmds.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (SETTLE) @(posedge aclk);
        if (awaited_cmds.size() != 0) begin
            $display("%0t: expected %0d more transactions, got none", $time,
                     awaited_cmds.size());
        end
        if (errors == 0 && awaited_cmds.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
